// ----- sv/rbia_pkg.sv -----
// Shared types, register indexes and sequencing constants for the impulse unit.
// No dependencies; every other file refers to it by scoped names.
package rbia_pkg;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] impulse_x;
        logic signed [31:0] impulse_y;
        logic signed [31:0] impulse_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_req;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] ang_x;
        logic signed [31:0] ang_y;
        logic signed [31:0] ang_z;
        logic               awake_flag;
    } t_rsp;

    localparam logic [2:0] REG_DYN         = 3'd0;
    localparam logic [2:0] REG_INV_MASS    = 3'd1;
    localparam logic [2:0] REG_INV_INERTIA = 3'd2;
    localparam logic [2:0] REG_POS_X       = 3'd3;
    localparam logic [2:0] REG_POS_Y       = 3'd4;
    localparam logic [2:0] REG_POS_Z       = 3'd5;
    localparam logic [2:0] REG_ORIENT      = 3'd6;

    localparam logic [1:0] MODE_LINEAR  = 2'd0;
    localparam logic [1:0] MODE_ANGULAR = 2'd1;
    localparam logic [1:0] MODE_POINT   = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [4:0] LIN_LAST   = 5'd3;
    localparam logic [4:0] CROSS_LAST = 5'd7;
    localparam logic [4:0] NORM_LAST  = 5'd4;
    localparam logic [4:0] SQRT_LAST  = 5'd30;
    localparam logic [4:0] DIV_LAST   = 5'd16;
    localparam logic [4:0] MAT_LAST   = 5'd10;
    localparam logic [4:0] ROT_LAST   = 5'd9;
    localparam logic [4:0] SCALE_LAST = 5'd3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DISP,
        OP_LIN,
        OP_CROSS,
        OP_NORM,
        OP_SQRT,
        OP_DIV,
        OP_MAT,
        OP_ROT1,
        OP_SCALE,
        OP_ROT2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] cnt;
        logic [1:0] comp;
        logic       in_load;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic       dyn;
        logic [1:0] mode;
    } t_sts;

    // row and column of the k-th term of a 3x3 matrix-vector product
    function automatic logic [1:0] rot_row(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] rot_col(input logic [3:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/rbia_ctrl.sv -----
// Sequencer of the impulse unit: handshakes and per-phase step counting.
// Depends on rbia_pkg; drives rbia_dp through t_cmd and reads t_sts.
module rbia_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  rbia_pkg::t_sts    i_sts,
    output rbia_pkg::t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DISP  = 12'b0000_0000_0010,
        S_LIN   = 12'b0000_0000_0100,
        S_CROSS = 12'b0000_0000_1000,
        S_NORM  = 12'b0000_0001_0000,
        S_SQRT  = 12'b0000_0010_0000,
        S_DIV   = 12'b0000_0100_0000,
        S_MAT   = 12'b0000_1000_0000,
        S_ROT1  = 12'b0001_0000_0000,
        S_SCALE = 12'b0010_0000_0000,
        S_ROT2  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_comp, n_comp;
    logic       r_rsp_valid, n_rsp_valid;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt + 5'd1;
        n_comp         = r_comp;
        o_cmd.op       = rbia_pkg::OP_NOP;
        o_cmd.cnt      = r_cnt;
        o_cmd.comp     = r_comp;
        o_cmd.in_load  = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_req_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.op = rbia_pkg::OP_DISP;
                n_cnt    = '0;
                if (!i_sts.dyn || i_sts.mode == rbia_pkg::MODE_UNUSED) begin
                    n_state = S_DONE;
                end else if (i_sts.mode == rbia_pkg::MODE_ANGULAR) begin
                    n_state = S_NORM;
                end else begin
                    n_state = S_LIN;
                end
            end
            S_LIN: begin
                o_cmd.op = rbia_pkg::OP_LIN;
                if (r_cnt == rbia_pkg::LIN_LAST) begin
                    n_cnt   = '0;
                    n_state = (i_sts.mode == rbia_pkg::MODE_POINT) ? S_CROSS : S_DONE;
                end
            end
            S_CROSS: begin
                o_cmd.op = rbia_pkg::OP_CROSS;
                if (r_cnt == rbia_pkg::CROSS_LAST) begin
                    n_cnt   = '0;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.op = rbia_pkg::OP_NORM;
                if (r_cnt == rbia_pkg::NORM_LAST) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.op = rbia_pkg::OP_SQRT;
                if (r_cnt == rbia_pkg::SQRT_LAST) begin
                    n_cnt   = '0;
                    n_comp  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = rbia_pkg::OP_DIV;
                if (r_cnt == rbia_pkg::DIV_LAST) begin
                    n_cnt  = '0;
                    n_comp = r_comp + 2'd1;
                    if (r_comp == 2'd3) begin
                        n_state = S_MAT;
                    end
                end
            end
            S_MAT: begin
                o_cmd.op = rbia_pkg::OP_MAT;
                if (r_cnt == rbia_pkg::MAT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_ROT1;
                end
            end
            S_ROT1: begin
                o_cmd.op = rbia_pkg::OP_ROT1;
                if (r_cnt == rbia_pkg::ROT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.op = rbia_pkg::OP_SCALE;
                if (r_cnt == rbia_pkg::SCALE_LAST) begin
                    n_cnt   = '0;
                    n_state = S_ROT2;
                end
            end
            S_ROT2: begin
                o_cmd.op = rbia_pkg::OP_ROT2;
                if (r_cnt == rbia_pkg::ROT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_cnt = '0;
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_comp      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_comp      <= n_comp;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

// ----- sv/rbia_dp.sv -----
// Datapath of the impulse unit: configuration, body state, one shared multiplier,
// bit-serial square root and divider. Depends on rbia_pkg; steered by rbia_ctrl.
module rbia_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_wr_data,
    input  rbia_pkg::t_req    i_req,
    input  rbia_pkg::t_cmd    i_cmd,
    output rbia_pkg::t_sts    o_sts,
    output rbia_pkg::t_rsp    o_rsp
);

    localparam logic signed [33:0] OneQ28 = 34'sd268435456;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
        logic signed [31:0] y;
        if ((&x[63:31]) || !(|x[63:31])) begin
            y = x[31:0];
        end else if (x[63]) begin
            y = 32'sh8000_0000;
        end else begin
            y = 32'sh7fff_ffff;
        end
        return y;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        logic signed [31:0] y;
        if (x[32] == x[31]) begin
            y = x[31:0];
        end else if (x[32]) begin
            y = 32'sh8000_0000;
        end else begin
            y = 32'sh7fff_ffff;
        end
        return y;
    endfunction

    // configuration and body state
    logic               r_dyn, n_dyn;
    logic [31:0]        r_inv_mass, n_inv_mass;
    logic [47:0]        r_inv_inertia, n_inv_inertia;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] n_pos [3];
    logic [63:0]        r_orient, n_orient;
    logic signed [31:0] r_vel [3];
    logic signed [31:0] n_vel [3];
    logic signed [31:0] r_ang [3];
    logic signed [31:0] n_ang [3];
    logic               r_awake, n_awake;

    // working registers
    logic [1:0]         r_mode, n_mode;
    logic signed [31:0] r_imp [3];
    logic signed [31:0] n_imp [3];
    logic signed [31:0] r_pt [3];
    logic signed [31:0] n_pt [3];
    logic signed [31:0] r_lev [3];
    logic signed [31:0] n_lev [3];
    logic signed [31:0] r_va [3];
    logic signed [31:0] n_va [3];
    logic signed [31:0] r_vb [3];
    logic signed [31:0] n_vb [3];
    logic signed [63:0] r_prod, n_prod;
    logic signed [63:0] r_acc, n_acc;
    logic               r_n2z, n_n2z;
    logic [60:0]        r_sn, n_sn;
    logic [60:0]        r_sres, n_sres;
    logic [44:0]        r_rem, n_rem;
    logic [15:0]        r_quo, n_quo;
    logic signed [15:0] r_qn [4];
    logic signed [15:0] n_qn [4];
    logic signed [31:0] r_p [9];
    logic signed [31:0] n_p [9];
    logic signed [31:0] r_m [9];
    logic signed [31:0] n_m [9];
    rbia_pkg::t_rsp     r_rsp, n_rsp;

    // combinational temporaries
    logic signed [15:0] qraw [4];
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [4:0]         km1, km2;
    logic [1:0]         ri, rj, ci, cj;
    logic signed [31:0] lin_d, rot_w;
    logic signed [63:0] sum, diff;
    logic [5:0]         sq_sh;
    logic [60:0]        sq_bit;
    logic [61:0]        sq_t;
    logic [30:0]        root;
    logic [15:0]        mag, quo_nx, qm;
    logic [3:0]         dk;
    logic [45:0]        dsh;
    logic               take;
    logic signed [33:0] pe [9];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qraw[i] = r_orient[16*i +: 16];
        end
        for (int i = 0; i < 9; i++) begin
            pe[i] = 34'(r_p[i]);
        end
    end

    assign mul_p = mul_a * mul_b;
    assign root  = r_sres[30:0];

    always_comb begin
        n_dyn         = r_dyn;
        n_inv_mass    = r_inv_mass;
        n_inv_inertia = r_inv_inertia;
        n_orient      = r_orient;
        n_pos         = r_pos;
        n_vel         = r_vel;
        n_ang         = r_ang;
        n_awake       = r_awake;
        n_mode        = r_mode;
        n_imp         = r_imp;
        n_pt          = r_pt;
        n_lev         = r_lev;
        n_va          = r_va;
        n_vb          = r_vb;
        n_acc         = r_acc;
        n_n2z         = r_n2z;
        n_sn          = r_sn;
        n_sres        = r_sres;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_qn          = r_qn;
        n_p           = r_p;
        n_m           = r_m;
        n_rsp         = r_rsp;
        mul_a         = '0;
        mul_b         = '0;
        km1           = i_cmd.cnt - 5'd1;
        km2           = i_cmd.cnt - 5'd2;
        ri            = rbia_pkg::rot_row(i_cmd.cnt[3:0]);
        rj            = rbia_pkg::rot_col(i_cmd.cnt[3:0]);
        ci            = rbia_pkg::rot_row(km1[3:0]);
        cj            = rbia_pkg::rot_col(km1[3:0]);
        lin_d         = '0;
        rot_w         = '0;
        sum           = '0;
        diff          = '0;
        sq_sh         = 6'(6'd60 - {i_cmd.cnt, 1'b0});
        sq_bit        = 61'(1) << sq_sh;
        sq_t          = {1'b0, r_sres} + {1'b0, sq_bit};
        mag           = qraw[i_cmd.comp][15] ? 16'(-qraw[i_cmd.comp]) : qraw[i_cmd.comp];
        dk            = 4'(5'd16 - i_cmd.cnt);
        dsh           = 46'(root) << dk;
        take          = ({1'b0, r_rem} >= dsh);
        quo_nx        = r_quo | (16'(take) << dk);
        qm            = (quo_nx > 16'd16384) ? 16'd16384 : quo_nx;

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rbia_pkg::REG_DYN:         n_dyn         = i_cfg_wr_data[0];
                rbia_pkg::REG_INV_MASS:    n_inv_mass    = i_cfg_wr_data[31:0];
                rbia_pkg::REG_INV_INERTIA: n_inv_inertia = i_cfg_wr_data[47:0];
                rbia_pkg::REG_POS_X:       n_pos[0]      = i_cfg_wr_data[31:0];
                rbia_pkg::REG_POS_Y:       n_pos[1]      = i_cfg_wr_data[31:0];
                rbia_pkg::REG_POS_Z:       n_pos[2]      = i_cfg_wr_data[31:0];
                rbia_pkg::REG_ORIENT:      n_orient      = i_cfg_wr_data;
                default: ;
            endcase
        end

        if (i_cmd.in_load) begin
            n_mode   = i_req.mode;
            n_imp[0] = i_req.impulse_x;
            n_imp[1] = i_req.impulse_y;
            n_imp[2] = i_req.impulse_z;
            n_pt[0]  = i_req.point_x;
            n_pt[1]  = i_req.point_y;
            n_pt[2]  = i_req.point_z;
        end

        if (i_cmd.out_load) begin
            n_rsp.vel_x      = r_vel[0];
            n_rsp.vel_y      = r_vel[1];
            n_rsp.vel_z      = r_vel[2];
            n_rsp.ang_x      = r_ang[0];
            n_rsp.ang_y      = r_ang[1];
            n_rsp.ang_z      = r_ang[2];
            n_rsp.awake_flag = r_awake;
        end

        unique case (i_cmd.op)
            rbia_pkg::OP_DISP: begin
                n_va = r_imp;
                if (r_dyn && r_mode != rbia_pkg::MODE_UNUSED) begin
                    n_awake = 1'b1;
                end
            end
            rbia_pkg::OP_LIN: begin
                if (i_cmd.cnt < 5'd3) begin
                    mul_a = 33'(r_imp[i_cmd.cnt[1:0]]);
                    mul_b = {1'b0, r_inv_mass};
                end
                if (i_cmd.cnt != 5'd0) begin
                    lin_d = sat64(r_prod >>> 16);
                    n_vel[km1[1:0]] = sat33(33'(r_vel[km1[1:0]]) + 33'(lin_d));
                end
            end
            rbia_pkg::OP_CROSS: begin
                if (i_cmd.cnt == 5'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_lev[i] = sat33(33'(r_pt[i]) - 33'(r_pos[i]));
                    end
                end else if (i_cmd.cnt < 5'd7) begin
                    case (km1[2:0])
                        3'd0:    begin mul_a = 33'(r_lev[1]); mul_b = 33'(r_imp[2]); end
                        3'd1:    begin mul_a = 33'(r_lev[2]); mul_b = 33'(r_imp[1]); end
                        3'd2:    begin mul_a = 33'(r_lev[2]); mul_b = 33'(r_imp[0]); end
                        3'd3:    begin mul_a = 33'(r_lev[0]); mul_b = 33'(r_imp[2]); end
                        3'd4:    begin mul_a = 33'(r_lev[0]); mul_b = 33'(r_imp[1]); end
                        default: begin mul_a = 33'(r_lev[1]); mul_b = 33'(r_imp[0]); end
                    endcase
                end
                if (i_cmd.cnt >= 5'd2) begin
                    if (!km2[0]) begin
                        n_acc = r_prod;
                    end else begin
                        diff = r_acc - r_prod;
                        n_va[km2[2:1]] = sat64(diff >>> 16);
                    end
                end
            end
            rbia_pkg::OP_NORM: begin
                if (i_cmd.cnt < 5'd4) begin
                    mul_a = 33'(qraw[i_cmd.cnt[1:0]]);
                    mul_b = 33'(qraw[i_cmd.cnt[1:0]]);
                end
                if (i_cmd.cnt != 5'd0) begin
                    sum   = ((i_cmd.cnt == 5'd1) ? 64'sd0 : r_acc) + r_prod;
                    n_acc = sum;
                    if (i_cmd.cnt == rbia_pkg::NORM_LAST) begin
                        n_n2z  = (sum == 64'sd0);
                        n_sn   = {sum[32:0], 28'd0};
                        n_sres = '0;
                    end
                end
            end
            rbia_pkg::OP_SQRT: begin
                if ({1'b0, r_sn} >= sq_t) begin
                    n_sn   = r_sn - sq_t[60:0];
                    n_sres = (r_sres >> 1) + sq_bit;
                end else begin
                    n_sres = r_sres >> 1;
                end
            end
            rbia_pkg::OP_DIV: begin
                if (i_cmd.cnt == 5'd0) begin
                    n_rem = {1'b0, mag, 28'd0} + 45'(root >> 1);
                    n_quo = '0;
                end else begin
                    if (take) begin
                        n_rem = r_rem - dsh[44:0];
                    end
                    n_quo = quo_nx;
                    if (i_cmd.cnt == rbia_pkg::DIV_LAST) begin
                        if (r_n2z) begin
                            n_qn[i_cmd.comp] = (i_cmd.comp == 2'd0) ? 16'sd16384 : 16'sd0;
                        end else if (qraw[i_cmd.comp][15]) begin
                            n_qn[i_cmd.comp] = 16'(-qm);
                        end else begin
                            n_qn[i_cmd.comp] = qm;
                        end
                    end
                end
            end
            rbia_pkg::OP_MAT: begin
                case (i_cmd.cnt[3:0])
                    4'd0: begin mul_a = 33'(r_qn[1]); mul_b = 33'(r_qn[1]); end
                    4'd1: begin mul_a = 33'(r_qn[2]); mul_b = 33'(r_qn[2]); end
                    4'd2: begin mul_a = 33'(r_qn[3]); mul_b = 33'(r_qn[3]); end
                    4'd3: begin mul_a = 33'(r_qn[1]); mul_b = 33'(r_qn[2]); end
                    4'd4: begin mul_a = 33'(r_qn[1]); mul_b = 33'(r_qn[3]); end
                    4'd5: begin mul_a = 33'(r_qn[2]); mul_b = 33'(r_qn[3]); end
                    4'd6: begin mul_a = 33'(r_qn[0]); mul_b = 33'(r_qn[1]); end
                    4'd7: begin mul_a = 33'(r_qn[0]); mul_b = 33'(r_qn[2]); end
                    4'd8: begin mul_a = 33'(r_qn[0]); mul_b = 33'(r_qn[3]); end
                    default: ;
                endcase
                if (i_cmd.cnt != 5'd0 && i_cmd.cnt < rbia_pkg::MAT_LAST) begin
                    n_p[km1[3:0]] = r_prod[31:0];
                end
                if (i_cmd.cnt == rbia_pkg::MAT_LAST) begin
                    n_m[0] = 32'(OneQ28 - 34'sd2 * (pe[1] + pe[2]));
                    n_m[1] = 32'(34'sd2 * (pe[3] - pe[8]));
                    n_m[2] = 32'(34'sd2 * (pe[4] + pe[7]));
                    n_m[3] = 32'(34'sd2 * (pe[3] + pe[8]));
                    n_m[4] = 32'(OneQ28 - 34'sd2 * (pe[0] + pe[2]));
                    n_m[5] = 32'(34'sd2 * (pe[5] - pe[6]));
                    n_m[6] = 32'(34'sd2 * (pe[4] - pe[7]));
                    n_m[7] = 32'(34'sd2 * (pe[5] + pe[6]));
                    n_m[8] = 32'(OneQ28 - 34'sd2 * (pe[0] + pe[1]));
                end
            end
            rbia_pkg::OP_ROT1, rbia_pkg::OP_ROT2: begin
                if (i_cmd.cnt < rbia_pkg::ROT_LAST) begin
                    if (i_cmd.op == rbia_pkg::OP_ROT1) begin
                        mul_a = 33'(r_m[4'(rj) * 4'd3 + 4'(ri)]);
                        mul_b = 33'(r_va[rj]);
                    end else begin
                        mul_a = 33'(r_m[4'(ri) * 4'd3 + 4'(rj)]);
                        mul_b = 33'(r_vb[rj]);
                    end
                end
                if (i_cmd.cnt != 5'd0) begin
                    sum   = ((cj == 2'd0) ? 64'sd0 : r_acc) + r_prod;
                    n_acc = sum;
                    if (cj == 2'd2) begin
                        rot_w = sat64(sum >>> 28);
                        if (i_cmd.op == rbia_pkg::OP_ROT1) begin
                            n_vb[ci] = rot_w;
                        end else begin
                            n_ang[ci] = sat33(33'(r_ang[ci]) + 33'(rot_w));
                        end
                    end
                end
            end
            rbia_pkg::OP_SCALE: begin
                if (i_cmd.cnt < 5'd3) begin
                    mul_a = 33'(r_vb[i_cmd.cnt[1:0]]);
                    mul_b = {17'd0, r_inv_inertia[16*i_cmd.cnt[1:0] +: 16]};
                end
                if (i_cmd.cnt != 5'd0) begin
                    n_vb[km1[1:0]] = sat64(r_prod >>> 8);
                end
            end
            default: ;
        endcase

        n_prod = mul_p[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn         <= 1'b1;
            r_inv_mass    <= 32'd65536;
            r_inv_inertia <= '0;
            r_orient      <= 64'd16384;
            r_awake       <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_ang[i] <= '0;
            end
        end else begin
            r_dyn         <= n_dyn;
            r_inv_mass    <= n_inv_mass;
            r_inv_inertia <= n_inv_inertia;
            r_orient      <= n_orient;
            r_awake       <= n_awake;
            r_pos         <= n_pos;
            r_vel         <= n_vel;
            r_ang         <= n_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_imp  <= n_imp;
        r_pt   <= n_pt;
        r_lev  <= n_lev;
        r_va   <= n_va;
        r_vb   <= n_vb;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_n2z  <= n_n2z;
        r_sn   <= n_sn;
        r_sres <= n_sres;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_qn   <= n_qn;
        r_p    <= n_p;
        r_m    <= n_m;
        r_rsp  <= n_rsp;
    end

    assign o_sts.dyn  = r_dyn;
    assign o_sts.mode = r_mode;
    assign o_rsp      = r_rsp;

endmodule

// ----- sv/rigid_body_impulse_apply_unit.sv -----
// Top level of the rigid body impulse unit: sequencer plus datapath.
// Depends on rbia_pkg, rbia_ctrl and rbia_dp.
//
// Usage: a request (mode, impulse, point) enters on i_req_valid/o_req_ready;
// the updated body velocities and awake flag leave on o_rsp_valid/i_rsp_ready,
// one response per request. Configuration is a plain write port (enable,
// index, 64-bit data), written only while the unit is idle; the user must
// keep to this, as the block does not enforce it. One request is worked on
// at a time; o_req_ready is high only when idle. The shared multiplier sets
// the matrix and rotation phases; the quaternion normalization dominates,
// with a 31-step square root and four 16-step divisions, one bit per cycle.
// The response sits in an output register, so a stalled receiver does not
// block the next request; only its completion waits until the register frees.
// Synchronous reset restores the default configuration, clears velocities
// and awake, and drops any pending response.
module rigid_body_impulse_apply_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_wr_data,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  rbia_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output rbia_pkg::t_rsp    o_rsp
);

    rbia_pkg::t_cmd cmd;
    rbia_pkg::t_sts sts;

    rbia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rbia_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (i_req),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_rsp         (o_rsp)
    );

endmodule

// ----- sv/rbia_checker.sv -----
// Port-level checks of the impulse unit, bound to the top level.
// Depends on rbia_pkg and rigid_body_impulse_apply_unit.
module rbia_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input rbia_pkg::t_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in flight");

    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !$rose(o_rsp_valid))
        else $error("response appeared right after request");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && o_req_ready)
        else $error("unit not idle after reset");

endmodule

bind rigid_body_impulse_apply_unit rbia_checker u_rbia_checker (.*);

// ----- bench/tb_rigid_body_impulse_apply_unit.sv -----
// Self-checking bench for rigid_body_impulse_apply_unit: a directed table, then random
// impulses, checked against an in-bench fixed-point model of the velocity update.
// Depends on rbia_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_rigid_body_impulse_apply_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_wr_en = 1'b0;
    logic [2:0]     i_cfg_index = '0;
    logic [63:0]    i_cfg_wr_data = '0;
    logic           i_req_valid = 1'b0;
    logic           o_req_ready;
    rbia_pkg::t_req i_req = '0;
    logic           o_rsp_valid;
    logic           i_rsp_ready = 1'b0;
    rbia_pkg::t_rsp o_rsp;

    rigid_body_impulse_apply_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    // body model
    logic [63:0] body_dyn, body_inv_mass, body_inertia, body_orient;
    logic [63:0] body_pos [3];
    longint      lin_vel [3];
    longint      ang_vel [3];
    bit          body_awake;

    rbia_pkg::t_rsp velocity_queue [$];
    int          mismatch_count = 0;
    int          rsp_count = 0;
    int          req_count = 0;
    int          mode_count [4];
    int          idle_cycles = 0;
    bit          timed_out = 0;
    bit          sink_calm = 0;
    int          sink_hold = 0;

    function automatic longint fl_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint q_slice(logic [63:0] v, int i);
        logic signed [15:0] s;
        s = v[16*i +: 16];
        return longint'(s);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic void build_rotation(output longint m [3][3]);
        longint q [4];
        longint unsigned n2, r, mag, num;
        longint c, w, x, y, z;
        n2 = 0;
        for (int i = 0; i < 4; i++) begin
            q[i] = q_slice(body_orient, i);
            n2 += longint'(q[i] * q[i]);
        end
        if (n2 == 0) begin
            q[0] = 16384; q[1] = 0; q[2] = 0; q[3] = 0;
        end else begin
            r = int_sqrt(n2 << 28);
            for (int i = 0; i < 4; i++) begin
                mag = q[i] < 0 ? -q[i] : q[i];
                num = (mag << 28) + (r >> 1);
                c = longint'(num / r);
                if (c > 16384) c = 16384;
                q[i] = q[i] < 0 ? -c : c;
            end
        end
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        m[0][0] = (64'sd1 << 28) - 2 * (y * y + z * z);
        m[0][1] = 2 * (x * y - w * z);
        m[0][2] = 2 * (x * z + w * y);
        m[1][0] = 2 * (x * y + w * z);
        m[1][1] = (64'sd1 << 28) - 2 * (x * x + z * z);
        m[1][2] = 2 * (y * z - w * x);
        m[2][0] = 2 * (x * z - w * y);
        m[2][1] = 2 * (y * z + w * x);
        m[2][2] = (64'sd1 << 28) - 2 * (x * x + y * y);
    endfunction

    function automatic void add_spin(input longint v [3]);
        longint m [3][3];
        longint loc [3], scl [3], wld [3];
        longint acc, k;
        build_rotation(m);
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += m[j][i] * v[j];
            loc[i] = sat32(fl_shift(acc, 28));
        end
        for (int i = 0; i < 3; i++) begin
            k = longint'(body_inertia[16*i +: 16]);
            scl[i] = sat32(fl_shift(loc[i] * k, 8));
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += m[i][j] * scl[j];
            wld[i] = sat32(fl_shift(acc, 28));
        end
        for (int i = 0; i < 3; i++) ang_vel[i] = sat32(ang_vel[i] + wld[i]);
    endfunction

    function automatic rbia_pkg::t_rsp apply_impulse(rbia_pkg::t_req rq);
        longint imp [3], pt [3], arm [3], crs [3];
        rbia_pkg::t_rsp r;
        imp[0] = rq.impulse_x; imp[1] = rq.impulse_y; imp[2] = rq.impulse_z;
        pt[0] = rq.point_x; pt[1] = rq.point_y; pt[2] = rq.point_z;
        if (body_dyn[0] && rq.mode != rbia_pkg::MODE_UNUSED) begin
            body_awake = 1;
            if (rq.mode != rbia_pkg::MODE_ANGULAR)
                for (int i = 0; i < 3; i++)
                    lin_vel[i] = sat32(lin_vel[i] + sat32(fl_shift(
                        imp[i] * longint'(body_inv_mass[31:0]), 16)));
            if (rq.mode == rbia_pkg::MODE_ANGULAR) begin
                add_spin(imp);
            end else if (rq.mode == rbia_pkg::MODE_POINT) begin
                for (int i = 0; i < 3; i++)
                    arm[i] = sat32(pt[i] - longint'($signed(body_pos[i][31:0])));
                crs[0] = sat32(fl_shift(arm[1] * imp[2] - arm[2] * imp[1], 16));
                crs[1] = sat32(fl_shift(arm[2] * imp[0] - arm[0] * imp[2], 16));
                crs[2] = sat32(fl_shift(arm[0] * imp[1] - arm[1] * imp[0], 16));
                add_spin(crs);
            end
        end
        r.vel_x = lin_vel[0][31:0]; r.vel_y = lin_vel[1][31:0]; r.vel_z = lin_vel[2][31:0];
        r.ang_x = ang_vel[0][31:0]; r.ang_y = ang_vel[1][31:0]; r.ang_z = ang_vel[2][31:0];
        r.awake_flag = body_awake;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (response %0d)", what, got, want, rsp_count);
        mismatch_count++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_req_valid <= 1'b0;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wr_data <= data;
        case (idx)
            rbia_pkg::REG_DYN:         body_dyn = data & 64'd1;
            rbia_pkg::REG_INV_MASS:    body_inv_mass = data & 64'hFFFF_FFFF;
            rbia_pkg::REG_INV_INERTIA: body_inertia = data & 64'hFFFF_FFFF_FFFF;
            rbia_pkg::REG_POS_X:       body_pos[0] = data & 64'hFFFF_FFFF;
            rbia_pkg::REG_POS_Y:       body_pos[1] = data & 64'hFFFF_FFFF;
            rbia_pkg::REG_POS_Z:       body_pos[2] = data & 64'hFFFF_FFFF;
            rbia_pkg::REG_ORIENT:      body_orient = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_and_settle();
        i_req_valid <= 1'b0;
        while (velocity_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // offer one request; hold until accepted
    task automatic send_request(rbia_pkg::t_req rq, bit calm);
        if (!calm) begin
            while ($urandom_range(99) < 12) begin
                i_req_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_req <= rq;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        velocity_queue.push_back(apply_impulse(rq));
        mode_count[rq.mode]++;
        req_count++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            default: return $urandom();
        endcase
    endfunction

    function automatic rbia_pkg::t_req rand_request();
        rbia_pkg::t_req rq;
        rq.mode = ($urandom_range(19) == 0) ? rbia_pkg::MODE_UNUSED : 2'($urandom_range(2));
        rq.impulse_x = rand_word(); rq.impulse_y = rand_word(); rq.impulse_z = rand_word();
        rq.point_x = rand_word(); rq.point_y = rand_word(); rq.point_z = rand_word();
        return rq;
    endfunction

    // response side
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            i_rsp_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            i_rsp_ready <= sink_calm ? 1'b1 : ($urandom_range(99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        rbia_pkg::t_rsp w;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            rsp_count++;
            if (velocity_queue.size() == 0) begin
                $display("unexpected response %0d", rsp_count);
                mismatch_count++;
            end else begin
                w = velocity_queue.pop_front();
                if (o_rsp.vel_x !== w.vel_x) report_mismatch("vel_x", o_rsp.vel_x, w.vel_x);
                if (o_rsp.vel_y !== w.vel_y) report_mismatch("vel_y", o_rsp.vel_y, w.vel_y);
                if (o_rsp.vel_z !== w.vel_z) report_mismatch("vel_z", o_rsp.vel_z, w.vel_z);
                if (o_rsp.ang_x !== w.ang_x) report_mismatch("ang_x", o_rsp.ang_x, w.ang_x);
                if (o_rsp.ang_y !== w.ang_y) report_mismatch("ang_y", o_rsp.ang_y, w.ang_y);
                if (o_rsp.ang_z !== w.ang_z) report_mismatch("ang_z", o_rsp.ang_z, w.ang_z);
                if (o_rsp.awake_flag !== w.awake_flag)
                    report_mismatch("awake", o_rsp.awake_flag, w.awake_flag);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) || i_cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d responses outstanding", velocity_queue.size());
            $display("tb_rigid_body_impulse_apply_unit: FAIL");
            $finish;
        end
    end

    typedef struct {
        rbia_pkg::t_req rq;
        bit             known;
        rbia_pkg::t_rsp want;
    } t_row;

    t_row directed_rows [$];

    function automatic rbia_pkg::t_req mk(logic [1:0] m, logic [31:0] ix, logic [31:0] iy,
                                          logic [31:0] iz, logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz);
        rbia_pkg::t_req rq;
        rq.mode = m; rq.impulse_x = ix; rq.impulse_y = iy; rq.impulse_z = iz;
        rq.point_x = px; rq.point_y = py; rq.point_z = pz;
        return rq;
    endfunction

    initial begin
        t_row           row;
        rbia_pkg::t_rsp got_want;
        int             random_total;
        body_dyn = 1; body_inv_mass = 65536; body_inertia = 0; body_orient = 16384;
        for (int i = 0; i < 3; i++) begin
            body_pos[i] = 0; lin_vel[i] = 0; ang_vel[i] = 0;
        end
        body_awake = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unused mode right after reset: all zero, still asleep
        row = '{mk(rbia_pkg::MODE_UNUSED, 32'h7FFF_FFFF, 0, 0, 0, 0, 0), 1, '0};
        directed_rows.push_back(row);
        // unit mass, linear impulse of one
        row = '{mk(rbia_pkg::MODE_LINEAR, 32'h1_0000, 32'hFFFF_0000, 0, 32'h7FFF_FFFF, 0, 0),
                1, '{32'h1_0000, 32'hFFFF_0000, 0, 0, 0, 0, 1'b1}};
        directed_rows.push_back(row);
        // zero inertia: angular leaves spin unchanged
        row = '{mk(rbia_pkg::MODE_ANGULAR, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 0), 1,
                '{32'h1_0000, 32'hFFFF_0000, 0, 0, 0, 0, 1'b1}};
        directed_rows.push_back(row);
        // saturate linear velocity both ways
        row = '{mk(rbia_pkg::MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   0, 0, 0), 1,
                '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1'b1}};
        directed_rows.push_back(row);
        row = '{mk(rbia_pkg::MODE_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h1_0000), 0, '0};
        directed_rows.push_back(row);
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].rq, 0);
            if (directed_rows[i].known) begin
                got_want = velocity_queue[$];
                if (got_want !== directed_rows[i].want) begin
                    $display("directed row %0d disagrees with typed result", i);
                    mismatch_count++;
                end
            end
        end
        drain_and_settle();

        // inertia on, rotated body, offset position
        write_reg(rbia_pkg::REG_INV_INERTIA, 64'h0100_0200_0080);
        write_reg(rbia_pkg::REG_ORIENT, {16'sd0, 16'sd11585, 16'sd0, 16'sd11585});
        write_reg(rbia_pkg::REG_POS_X, 32'hFFFF_0000);
        write_reg(rbia_pkg::REG_POS_Y, 32'h0002_0000);
        write_reg(rbia_pkg::REG_POS_Z, 32'h7FFF_FFFF);
        write_reg(rbia_pkg::REG_INV_MASS, 32'h0000_8000);
        for (int i = 0; i < 3; i++)
            send_request(mk(2'(i), 32'h3_0000, 32'hFFFE_0000, 32'h1_8000,
                            32'h5_0000, 32'h8000_0000, 32'h7FFF_FFFF), 0);
        drain_and_settle();
        // zero quaternion, full-scale inertia and mass
        write_reg(rbia_pkg::REG_ORIENT, 64'd0);
        write_reg(rbia_pkg::REG_INV_INERTIA, 64'hFFFF_FFFF_FFFF);
        write_reg(rbia_pkg::REG_INV_MASS, 32'hFFFF_FFFF);
        send_request(mk(rbia_pkg::MODE_ANGULAR, 32'h0000_0100, 32'hFFFF_FF00, 32'h7FFF_FFFF,
                        0, 0, 0), 0);
        send_request(mk(rbia_pkg::MODE_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h0), 0);
        drain_and_settle();
        // static body reports state unchanged
        write_reg(rbia_pkg::REG_DYN, 64'd0);
        send_request(mk(rbia_pkg::MODE_LINEAR, 32'h1234_5678, 0, 0, 0, 0, 0), 0);
        send_request(mk(rbia_pkg::MODE_POINT, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6), 0);
        drain_and_settle();
        write_reg(rbia_pkg::REG_DYN, 64'd1);
        write_reg(rbia_pkg::REG_INV_MASS, 32'd0);
        send_request(mk(rbia_pkg::MODE_LINEAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        0, 0, 0), 0);
        drain_and_settle();

        random_total = 0;
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(rbia_pkg::REG_DYN, ($urandom_range(5) == 0) ? 64'd0 : 64'd1);
            write_reg(rbia_pkg::REG_INV_MASS,
                      phase == 0 ? 64'hFFFF_FFFF : {32'd0, $urandom_range(0, 32'h4_0000)});
            write_reg(rbia_pkg::REG_INV_INERTIA,
                      phase == 1 ? 64'hFFFF_FFFF_FFFF
                                 : {16'd0, 16'($urandom()), $urandom()});
            write_reg(rbia_pkg::REG_POS_X, {32'd0, rand_word()});
            write_reg(rbia_pkg::REG_POS_Y, {32'd0, rand_word()});
            write_reg(rbia_pkg::REG_POS_Z, {32'd0, rand_word()});
            write_reg(rbia_pkg::REG_ORIENT, phase == 2 ? 64'd0 : {$urandom(), $urandom()});
            if (phase == 3) sink_hold = 600;
            sink_calm = (phase == 4);
            for (int n = 0; n < 105; n++) begin
                send_request(rand_request(), phase == 3 || phase == 4);
                random_total++;
                if (phase == 5 && n == 50) drain_and_settle();
            end
            drain_and_settle();
            sink_calm = 0;
        end

        $display("covered %0d requests (linear %0d, angular %0d, point %0d, unused %0d)",
                 req_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        $display("%0d responses checked over 6 random configurations", rsp_count);
        if (mismatch_count == 0 && velocity_queue.size() == 0) begin
            $display("tb_rigid_body_impulse_apply_unit: PASS");
        end else begin
            $display("tb_rigid_body_impulse_apply_unit: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rbia_pkg.sv
sv/rbia_ctrl.sv
sv/rbia_dp.sv
sv/rigid_body_impulse_apply_unit.sv
sv/rbia_checker.sv
bench/tb_rigid_body_impulse_apply_unit.sv
